// ===== rtl/core/csq_pkg.sv =====
// Shared types, command and result codes for the clip stack quad index builder.
package csq_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;
  localparam logic [1:0] CMD_END  = 2'd3;

  localparam logic [1:0] KIND_CLIP   = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam int QUAD_WORDS  = 6;
  localparam int SHAPE_SHIFT = 2;
  localparam int CLIP_SHIFT  = 18;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] clip_min_x;
    logic signed [15:0] clip_min_y;
    logic signed [15:0] clip_max_x;
    logic signed [15:0] clip_max_y;
    logic [63:0]        shape_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               accepted;
    logic [31:0]        index_word;
    logic [13:0]        index_position;
    logic [10:0]        shape_slot;
    logic [63:0]        shape_out;
    logic [9:0]         clip_slot;
    logic signed [15:0] out_min_x;
    logic signed [15:0] out_min_y;
    logic signed [15:0] out_max_x;
    logic signed [15:0] out_max_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
  } rect_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] arg;
  } csq_item_t;

  localparam rect_t FULL_RECT = '{min_x: 16'sd0, min_y: 16'sd0,
                                  max_x: 16'sd32767, max_y: 16'sd32767};

  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0: c = 2'd0;
      3'd1: c = 2'd1;
      3'd2: c = 2'd2;
      3'd3: c = 2'd2;
      3'd4: c = 2'd1;
      3'd5: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/clip_stack_quad_index_builder_unit.sv =====
// Top level of the clip stack quad index builder: front queue and back end.
//
// Commands enter on in_valid/in_ready/in_data (push clip, pop clip, draw shape,
// end frame) and results leave on out_valid/out_ready/out_data, one item per
// result, with last set on the final result of each command.
// The front holds a two-entry command queue, so in_ready stays high while an
// entry is free, also while the back end works on an earlier command or waits
// on the output register. An accepted push or pop first reads the clip store
// or clip stack, then in state S_PUSH or S_POP loads its result into the
// output register; draw, end frame and rejected commands load their first
// result straight from the queue head. A draw emits six index words at one per
// cycle while out_ready lets the output register drain.
// The single output register sets the rate: one result per cycle at most.
// Reset (rst_n low at a clock edge) empties the queue and output register and
// restores the full-area base clip as the only clip, with other counts cleared.
// When the receiver holds out_ready low the result stays on out_data, the back
// end waits to load its next result, and the front keeps filling its queue.
module clip_stack_quad_index_builder_unit #(
  parameter int MAX_CLIPS   = 1024,
  parameter int STACK_DEPTH = 32,
  parameter int MAX_SHAPES  = 2048,
  parameter int MAX_INDICES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output csq_pkg::out_item_t out_data
);

  logic               head_valid;
  csq_pkg::csq_item_t head;
  logic               head_pop;

  csq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  csq_back #(
    .MAX_CLIPS   (MAX_CLIPS),
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_SHAPES  (MAX_SHAPES),
    .MAX_INDICES (MAX_INDICES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/core/csq_front.sv =====
// Input side: accepts commands, packs the operand and queues them for the back end.
module csq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csq_pkg::in_item_t  in_data,
  output logic               head_valid,
  output csq_pkg::csq_item_t head,
  input  logic               head_pop
);

  csq_pkg::csq_item_t q_r [2];
  logic [1:0]         count_r, count_nxt;
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  csq_pkg::csq_item_t item;
  csq_pkg::rect_t     rect;
  logic               push;
  logic               pop;

  assign in_ready   = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign push       = in_valid && in_ready;
  assign pop        = head_pop && head_valid;

  always_comb begin
    rect.min_x = in_data.clip_min_x;
    rect.min_y = in_data.clip_min_y;
    rect.max_x = in_data.clip_max_x;
    rect.max_y = in_data.clip_max_y;
    item.op    = in_data.cmd;
    if (in_data.cmd == csq_pkg::CMD_DRAW) begin
      item.arg = in_data.shape_data;
    end else begin
      item.arg = rect;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

// ===== rtl/core/csq_back.sv =====
// Back end: clip store, clip stack, counters, command sequencer and result register.
module csq_back #(
  parameter int MAX_CLIPS   = 1024,
  parameter int STACK_DEPTH = 32,
  parameter int MAX_SHAPES  = 2048,
  parameter int MAX_INDICES = 16384
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  csq_pkg::csq_item_t head,
  output logic               head_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output csq_pkg::out_item_t out_data
);

  localparam int CLIP_W = $clog2(MAX_CLIPS);
  localparam int CCNT_W = $clog2(MAX_CLIPS + 1);
  localparam int STK_W  = $clog2(STACK_DEPTH);
  localparam int SCNT_W = $clog2(MAX_SHAPES + 1);
  localparam int ICNT_W = $clog2(MAX_INDICES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_DRAW = 2'd3;

  csq_pkg::rect_t    clip_store [MAX_CLIPS];
  logic [CLIP_W-1:0] stk_mem [STACK_DEPTH];

  logic [1:0]         state_r, state_nxt;
  logic [CCNT_W-1:0]  clip_count_r, clip_count_nxt;
  logic [STK_W-1:0]   top_r, top_nxt;
  logic [CLIP_W-1:0]  active_r, active_nxt;
  logic [SCNT_W-1:0]  shape_count_r, shape_count_nxt;
  logic [ICNT_W-1:0]  index_count_r, index_count_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  csq_pkg::out_item_t out_data_r;

  csq_pkg::rect_t    store_rd_r;
  logic              store_base_r;
  logic [CLIP_W-1:0] stk_rd_r;
  logic              stk_base_r;

  logic               store_re, store_we, stk_re, stk_we;
  logic               load;
  logic               can_emit;
  csq_pkg::out_item_t res;
  csq_pkg::out_item_t status_ok;
  csq_pkg::out_item_t status_bad;
  csq_pkg::out_item_t word;
  csq_pkg::rect_t     rect_in;
  csq_pkg::rect_t     cur;
  csq_pkg::rect_t     isect;
  logic [31:0]        cc32, act32, sh32, ix32;
  logic               push_full, draw_full;

  assign can_emit = !out_valid_r || out_ready;
  assign rect_in  = csq_pkg::rect_t'(head.arg);
  assign cur      = store_base_r ? csq_pkg::FULL_RECT : store_rd_r;
  assign cc32     = 32'(clip_count_r);
  assign act32    = 32'(active_r);
  assign sh32     = 32'(shape_count_r);
  assign ix32     = 32'(index_count_r);

  assign push_full = (top_r == STK_W'(STACK_DEPTH - 1)) ||
                     (clip_count_r == CCNT_W'(MAX_CLIPS));
  assign draw_full = (index_count_r > ICNT_W'(MAX_INDICES - csq_pkg::QUAD_WORDS)) ||
                     (shape_count_r == SCNT_W'(MAX_SHAPES));

  always_comb begin
    isect.min_x = (cur.min_x > rect_in.min_x) ? cur.min_x : rect_in.min_x;
    isect.min_y = (cur.min_y > rect_in.min_y) ? cur.min_y : rect_in.min_y;
    isect.max_x = (cur.max_x < rect_in.max_x) ? cur.max_x : rect_in.max_x;
    isect.max_y = (cur.max_y < rect_in.max_y) ? cur.max_y : rect_in.max_y;
  end

  always_comb begin
    status_ok          = '0;
    status_ok.kind     = csq_pkg::KIND_STATUS;
    status_ok.accepted = 1'b1;
    status_ok.last     = 1'b1;
    status_bad         = status_ok;
    status_bad.accepted = 1'b0;

    word                = '0;
    word.kind           = csq_pkg::KIND_INDEX;
    word.accepted       = 1'b1;
    word.index_word     = 32'(csq_pkg::corner_of(cnt_r)) |
                          (sh32 << csq_pkg::SHAPE_SHIFT) |
                          (act32 << csq_pkg::CLIP_SHIFT);
    word.index_position = ix32[13:0];
    word.shape_slot     = sh32[10:0];
    word.shape_out      = head.arg;
    word.clip_slot      = act32[9:0];
    word.last           = (cnt_r == 3'(csq_pkg::QUAD_WORDS - 1));
  end

  always_comb begin
    state_nxt       = state_r;
    clip_count_nxt  = clip_count_r;
    top_nxt         = top_r;
    active_nxt      = active_r;
    shape_count_nxt = shape_count_r;
    index_count_nxt = index_count_r;
    cnt_nxt         = cnt_r;
    head_pop        = 1'b0;
    load            = 1'b0;
    res             = status_ok;
    store_re        = 1'b0;
    store_we        = 1'b0;
    stk_re          = 1'b0;
    stk_we          = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          case (head.op)
            csq_pkg::CMD_PUSH: begin
              if (push_full) begin
                if (can_emit) begin
                  res      = status_bad;
                  load     = 1'b1;
                  head_pop = 1'b1;
                end
              end else begin
                store_re  = 1'b1;
                state_nxt = S_PUSH;
              end
            end
            csq_pkg::CMD_POP: begin
              if (top_r == '0) begin
                if (can_emit) begin
                  res      = status_bad;
                  load     = 1'b1;
                  head_pop = 1'b1;
                end
              end else begin
                stk_re    = 1'b1;
                top_nxt   = top_r - STK_W'(1);
                state_nxt = S_POP;
              end
            end
            csq_pkg::CMD_DRAW: begin
              if (can_emit) begin
                if (draw_full) begin
                  res      = status_bad;
                  load     = 1'b1;
                  head_pop = 1'b1;
                end else begin
                  res             = word;
                  load            = 1'b1;
                  cnt_nxt         = cnt_r + 3'd1;
                  index_count_nxt = index_count_r + ICNT_W'(1);
                  state_nxt       = S_DRAW;
                end
              end
            end
            default: begin
              if (can_emit) begin
                res             = status_ok;
                load            = 1'b1;
                head_pop        = 1'b1;
                clip_count_nxt  = CCNT_W'(1);
                top_nxt         = '0;
                active_nxt      = '0;
                shape_count_nxt = '0;
                index_count_nxt = '0;
              end
            end
          endcase
        end
      end
      S_PUSH: begin
        if (can_emit) begin
          res           = '0;
          res.kind      = csq_pkg::KIND_CLIP;
          res.accepted  = 1'b1;
          res.clip_slot = cc32[9:0];
          res.out_min_x = isect.min_x;
          res.out_min_y = isect.min_y;
          res.out_max_x = isect.max_x;
          res.out_max_y = isect.max_y;
          res.last      = 1'b1;
          load          = 1'b1;
          head_pop      = 1'b1;
          store_we      = 1'b1;
          stk_we        = 1'b1;
          clip_count_nxt = clip_count_r + CCNT_W'(1);
          top_nxt       = top_r + STK_W'(1);
          active_nxt    = CLIP_W'(clip_count_r);
          state_nxt     = S_IDLE;
        end
      end
      S_POP: begin
        if (can_emit) begin
          res        = status_ok;
          load       = 1'b1;
          head_pop   = 1'b1;
          active_nxt = stk_base_r ? '0 : stk_rd_r;
          state_nxt  = S_IDLE;
        end
      end
      S_DRAW: begin
        if (can_emit) begin
          res             = word;
          load            = 1'b1;
          index_count_nxt = index_count_r + ICNT_W'(1);
          if (cnt_r == 3'(csq_pkg::QUAD_WORDS - 1)) begin
            cnt_nxt         = 3'd0;
            shape_count_nxt = shape_count_r + SCNT_W'(1);
            head_pop        = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (store_we) begin
      clip_store[CLIP_W'(clip_count_r)] <= isect;
    end
    if (store_re) begin
      store_rd_r   <= clip_store[active_r];
      store_base_r <= (active_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[top_r + STK_W'(1)] <= CLIP_W'(clip_count_r);
    end
    if (stk_re) begin
      stk_rd_r   <= stk_mem[top_r - STK_W'(1)];
      stk_base_r <= (top_r == STK_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      clip_count_r  <= CCNT_W'(1);
      top_r         <= '0;
      active_r      <= '0;
      shape_count_r <= '0;
      index_count_r <= '0;
      cnt_r         <= 3'd0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clip_count_r  <= clip_count_nxt;
      top_r         <= top_nxt;
      active_r      <= active_nxt;
      shape_count_r <= shape_count_nxt;
      index_count_r <= index_count_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
